>>> rtl/rit_pkg.sv
`timescale 1ns / 1ps

package rit_pkg;

	localparam int ADC_W  = 10;
	localparam int TEMP_W = 12;
	localparam int CFG_W  = 10;
	localparam int CNT_W  = 14;
	localparam int CONV_W = 28;

	localparam logic [CONV_W-1:0] GAIN_Q16 = 28'd171703;
	localparam logic [CONV_W-1:0] OFFS_Q16 = 28'd7201758;

	localparam logic [TEMP_W-1:0] TEMP_MAX = 12'd2570;

	localparam logic [CFG_W-1:0] TARGET_RST = 10'd185;
	localparam logic [CFG_W-1:0] NEAR_RST   = 10'd170;

	typedef enum logic [0:0] {
		REG_TARGET_TEMP = 1'b0,
		REG_NEAR_TEMP   = 1'b1
	} reg_idx_t;

endpackage

>>> rtl/relay_iron_temperature_controller.sv
// channel  | direction | tdata fields (lsb first)
// s_*      | in        | adc_reading[9:0], key_pressed[10], zero[15:11]
// m_*      | out       | relay_on[0], activity_led[1], lock_led[2], stopped[3],
//          |           | temperature[15:4]
// cfg_*    | in        | write only, index 0 target_temp, 1 near_temp
//
// One item per cycle sustained while the output is not stalled.
// Stage one holds the item, stage two the converted reading, and the
// controller state is updated as the result register loads.
// Reset clears valid flags and controller state but sets stopped; cfg reloads.
// A stalled output holds its stages; s_tready falls once all are full.
`timescale 1ns / 1ps

module relay_iron_temperature_controller #(
	parameter int TICKS_PER_SECOND = 100
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [15:0]               s_tdata,   // adc_reading, key_pressed
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [15:0]               m_tdata,   // relay_on, activity_led, lock_led,
	                                             // stopped, temperature
	input  logic                      cfg_wr_en,
	input  logic [0:0]                cfg_index,
	input  logic [rit_pkg::CFG_W-1:0] cfg_data
);
	import rit_pkg::*;

	localparam int K9 = (9 * TICKS_PER_SECOND) / 15;
	localparam int K6 = (6 * TICKS_PER_SECOND) / 15;
	localparam int KW = $clog2(K9 + 1);
	localparam int SW = 13 + KW + 2;

	localparam logic [CNT_W-1:0] QTR_H  = CNT_W'(TICKS_PER_SECOND / 4);
	localparam logic [CNT_W-1:0] HALF_H = CNT_W'(TICKS_PER_SECOND / 2);
	localparam logic [CNT_W-1:0] FIVE_H = CNT_W'(5 * TICKS_PER_SECOND);
	localparam logic [CNT_W-1:0] TEN_H  = CNT_W'(10 * TICKS_PER_SECOND);
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	logic [CFG_W-1:0]  target_q, near_q;

	logic              v_s1, v_s2;
	logic [ADC_W-1:0]  adc_s1;
	logic              key_s1, key_s2;
	logic [TEMP_W-1:0] conv_s2;

	logic              rdy_out, rdy_s2, rdy_s1, adv_out;

	logic [TEMP_W-1:0] iron_q;
	logic              stop_q, relay_q, lock_q, act_q;
	logic [CNT_W-1:0]  sw_cnt_q, ms_cnt_q;
	logic              out_v_q;

	logic [CONV_W-1:0] prod_c, diff_c;
	logic [TEMP_W-1:0] conv_c;

	logic [CNT_W-1:0]  sw_inc, ms_inc, sw_nx, ms_nx;
	logic              measure;
	logic [TEMP_W-1:0] temp_nx;
	logic signed [SW-1:0] diff_pt, kmul, prod_pt, raw;
	logic [CNT_W-1:0]  clamped, period;
	logic              relay_k, act_k, stop_nx;
	logic              relay_nx, act_nx, lock_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RST;
			near_q   <= NEAR_RST;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TARGET_TEMP: target_q <= cfg_data;
				REG_NEAR_TEMP:   near_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rdy_out  = !out_v_q || m_tready;
	assign rdy_s2   = !v_s2 || rdy_out;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;
	assign adv_out  = v_s2 && rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (rdy_s1)  v_s1    <= s_tvalid;
			if (rdy_s2)  v_s2    <= v_s1;
			if (rdy_out) out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			adc_s1 <= s_tdata[ADC_W-1:0];
			key_s1 <= s_tdata[ADC_W];
		end
		if (rdy_s2 && v_s1) begin
			conv_s2 <= conv_c;
			key_s2  <= key_s1;
		end
	end

	// reading to degrees, Q16 gain and offset
	always_comb begin
		prod_c = CONV_W'(adc_s1) * GAIN_Q16;
		diff_c = prod_c - OFFS_Q16;
		conv_c = (prod_c > OFFS_Q16) ? diff_c[CONV_W-1:16] : '0;
	end

	always_comb begin
		sw_inc = (sw_cnt_q == CNT_MAX) ? sw_cnt_q : sw_cnt_q + 1'b1;
		ms_inc = (ms_cnt_q == CNT_MAX) ? ms_cnt_q : ms_cnt_q + 1'b1;

		measure = !relay_q && (ms_inc > QTR_H);
		temp_nx = measure ? conv_s2 : iron_q;
		ms_nx   = measure ? '0 : ms_inc;

		diff_pt = $signed(SW'(target_q)) - $signed(SW'(temp_nx));
		kmul    = relay_q ? $signed(SW'(K6)) : $signed(SW'(K9));
		prod_pt = diff_pt * kmul;
		raw     = relay_q ? prod_pt : $signed(SW'(TEN_H)) - prod_pt;

		if (raw[SW-1])
			clamped = '0;
		else if (raw > $signed(SW'(TEN_H)))
			clamped = TEN_H;
		else
			clamped = raw[CNT_W-1:0];

		if (!relay_q)
			period = (temp_nx > TEMP_W'(near_q)) ? clamped : HALF_H;
		else
			period = (temp_nx < TEMP_W'(near_q)) ? FIVE_H : clamped;
		if (temp_nx > TEMP_W'(target_q))
			period = '0;

		relay_k = key_s2 ? 1'b0 : relay_q;
		act_k   = key_s2 ? 1'b0 : act_q;
		stop_nx = stop_q ^ key_s2;
		if (stop_nx)
			period = QTR_H;

		relay_nx = relay_k;
		act_nx   = act_k;
		lock_nx  = lock_q;
		sw_nx    = sw_inc;
		if (sw_inc > period) begin
			sw_nx = '0;
			if (period == '0 || stop_nx) begin
				relay_nx = 1'b0;
				if (stop_nx)
					lock_nx = !lock_q;
				else
					act_nx = 1'b0;
			end else begin
				relay_nx = !relay_k;
				act_nx   = !relay_k;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iron_q   <= '0;
			stop_q   <= 1'b1;
			relay_q  <= 1'b0;
			lock_q   <= 1'b0;
			act_q    <= 1'b0;
			sw_cnt_q <= '0;
			ms_cnt_q <= '0;
		end else if (adv_out) begin
			iron_q   <= temp_nx;
			stop_q   <= stop_nx;
			relay_q  <= relay_nx;
			lock_q   <= lock_nx;
			act_q    <= act_nx;
			sw_cnt_q <= sw_nx;
			ms_cnt_q <= ms_nx;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {iron_q, stop_q, lock_q, act_q, relay_q};

endmodule

>>> rtl/rit_checker.sv
`timescale 1ns / 1ps

module rit_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);
	import rit_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	a_no_heat_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[3]))
		else $error("relay energised in stop mode");

	a_led_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1] == m_tdata[0])
		else $error("activity led differs from relay");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:4] <= TEMP_MAX)
		else $error("temperature beyond conversion range");

endmodule

bind relay_iron_temperature_controller rit_checker u_rit_checker (.*);
